### hw/rtl/pts_pkg.sv
// publish topic scanner: shared constants, widths and the work record type
// used by the parser front, the work queue and the result back end
// no dependencies
package pts_pkg;

    // header and topic byte codes
    localparam logic [7:0] MARKER_BYTE = 8'h80;
    localparam logic [7:0] QOS0_BYTE   = 8'h30;
    localparam logic [7:0] QOS2_BYTE   = 8'h34;
    localparam logic [7:0] PRINT_LO    = 8'd32;
    localparam logic [7:0] PRINT_HI    = 8'd126;

    // the qos byte sits four bytes after the marker, the length byte seven after
    localparam int LEN_OFFSET = 7;
    localparam int QOS_OFFSET = 4;
    localparam int SKIP_W     = 2;
    localparam logic [SKIP_W-1:0] SKIP_INIT = SKIP_W'(LEN_OFFSET - QOS_OFFSET - 1);

    // history window of past bytes
    localparam int WINDOW_DEPTH = QOS_OFFSET;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    // stream widths
    localparam int CHAR_W      = 7;
    localparam int COUNT_W     = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // work queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // what one accepted byte asks the back end to send
    typedef struct packed {
        logic               has_char;
        logic [CHAR_W-1:0]  topic_char;
        logic               has_sum;
        logic               found_valid;
        logic               qos_level;
        logic [COUNT_W-1:0] printable_count;
    } t_work;

    // queue status seen by the top level and the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

### hw/rtl/pts_front.sv
// publish topic scanner front: parses each accepted byte and builds a work record
// depends on pts_pkg
module pts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_push,
    output pts_pkg::t_work                o_work
);

    typedef enum logic [2:0] {
        PH_SCAN  = 3'd0,
        PH_SKIP  = 3'd1,
        PH_LEN   = 3'd2,
        PH_TOPIC = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [7:0]                          r_win [pts_pkg::WINDOW_DEPTH];
    logic [pts_pkg::FILL_W-1:0]          r_fill, n_fill;
    logic [pts_pkg::SKIP_W-1:0]          r_skip, n_skip;
    logic [7:0]                          r_remain, n_remain;
    logic                                r_qos, n_qos;
    logic [pts_pkg::COUNT_W-1:0]         r_count, n_count;
    logic                                w_printable;
    logic                                w_emit_char;
    logic                                w_match;

    assign w_printable = (i_data_byte >= pts_pkg::PRINT_LO) &&
                         (i_data_byte <= pts_pkg::PRINT_HI);

    assign w_match = (r_fill == pts_pkg::FILL_W'(pts_pkg::WINDOW_DEPTH)) &&
                     (r_win[0] == pts_pkg::MARKER_BYTE) &&
                     ((i_data_byte == pts_pkg::QOS0_BYTE) ||
                      (i_data_byte == pts_pkg::QOS2_BYTE));

    // phase step for the current byte
    always_comb begin
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_remain    = r_remain;
        n_qos       = r_qos;
        n_count     = r_count;
        w_emit_char = 1'b0;
        case (r_phase)
            PH_SKIP: begin
                n_skip = r_skip - 1'b1;
                if (n_skip == '0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_remain = i_data_byte;
                n_phase  = (i_data_byte == 8'd0) ? PH_DONE : PH_TOPIC;
            end
            PH_TOPIC: begin
                if (w_printable) begin
                    w_emit_char = 1'b1;
                    n_count     = r_count + 1'b1;
                end
                n_remain = r_remain - 1'b1;
                if (n_remain == 8'd0) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
                // scanning; unused codes behave the same
                if (w_match) begin
                    n_qos   = (i_data_byte == pts_pkg::QOS2_BYTE);
                    n_skip  = pts_pkg::SKIP_INIT;
                    n_phase = PH_SKIP;
                end
            end
        endcase
        n_fill = (r_fill == pts_pkg::FILL_W'(pts_pkg::WINDOW_DEPTH)) ?
                 r_fill : r_fill + 1'b1;
    end

    // work record for the back end
    always_comb begin
        o_work.has_char        = w_emit_char;
        o_work.topic_char      = i_data_byte[pts_pkg::CHAR_W-1:0];
        o_work.has_sum         = i_last_byte;
        o_work.found_valid     = (n_phase == PH_DONE);
        o_work.qos_level       = (n_phase == PH_DONE) ? n_qos : 1'b0;
        o_work.printable_count = n_count;
    end

    assign o_push = i_accept && (w_emit_char || i_last_byte);

    // parser state, cleared again after the last byte of a payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase  <= PH_SCAN;
            r_fill   <= '0;
            r_skip   <= '0;
            r_remain <= '0;
            r_qos    <= 1'b0;
            r_count  <= '0;
            for (int k = 0; k < pts_pkg::WINDOW_DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_skip   <= n_skip;
            r_remain <= n_remain;
            r_qos    <= n_qos;
            r_count  <= n_count;
            for (int k = 0; k < pts_pkg::WINDOW_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[pts_pkg::WINDOW_DEPTH-1] <= i_data_byte;
        end
    end

endmodule

### hw/rtl/pts_queue.sv
// publish topic scanner work queue: short fifo of work records between front and back
// depends on pts_pkg
module pts_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pts_pkg::t_work         i_work,
    input  logic                   i_pop,
    output pts_pkg::t_work         o_work,
    output pts_pkg::t_queue_status o_status
);

    pts_pkg::t_work              r_mem [pts_pkg::QUEUE_DEPTH];
    logic [pts_pkg::QPTR_W-1:0]  r_wptr;
    logic [pts_pkg::QPTR_W-1:0]  r_rptr;
    logic [pts_pkg::QCNT_W-1:0]  r_cnt;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == pts_pkg::QCNT_W'(pts_pkg::QUEUE_DEPTH));
    assign o_work         = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    // pointers and fill level; pointers wrap on their own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/pts_back.sv
// publish topic scanner back end: turns work records into one or two result beats
// depends on pts_pkg
module pts_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pts_pkg::t_work                     i_work,
    input  pts_pkg::t_queue_status             i_status,
    output logic                               o_pop,
    input  logic                               i_tready,
    output logic                               o_tvalid,
    output logic [pts_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic                               o_tuser,
    output logic                               o_tlast
);

    localparam int PAD_W = pts_pkg::OUT_TDATA_W - pts_pkg::CHAR_W - 2 - pts_pkg::COUNT_W;

    logic                          r_tvalid;
    logic [pts_pkg::OUT_TDATA_W-1:0] r_tdata;
    logic                          r_tuser;
    logic                          r_tlast;
    logic                          r_pend;
    logic                          r_pend_valid;
    logic                          r_pend_qos;
    logic [pts_pkg::COUNT_W-1:0]   r_pend_count;
    logic                          w_load;

    assign w_load = !r_tvalid || i_tready;
    assign o_pop  = w_load && !r_pend && !i_status.empty;

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

    // output register and pending summary held behind a character beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_pend   <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_tvalid <= 1'b1;
                r_tuser  <= 1'b1;
                r_tlast  <= 1'b1;
                r_tdata  <= {PAD_W'(0), r_pend_count, r_pend_qos, r_pend_valid,
                             pts_pkg::CHAR_W'(0)};
                r_pend   <= 1'b0;
            end else if (!i_status.empty) begin
                r_tvalid <= 1'b1;
                if (i_work.has_char) begin
                    r_tuser      <= 1'b0;
                    r_tlast      <= !i_work.has_sum;
                    r_tdata      <= {PAD_W'(0), pts_pkg::COUNT_W'(0), 2'b00,
                                     i_work.topic_char};
                    r_pend       <= i_work.has_sum;
                    r_pend_valid <= i_work.found_valid;
                    r_pend_qos   <= i_work.qos_level;
                    r_pend_count <= i_work.printable_count;
                end else begin
                    r_tuser <= 1'b1;
                    r_tlast <= 1'b1;
                    r_tdata <= {PAD_W'(0), i_work.printable_count, i_work.qos_level,
                                i_work.found_valid, pts_pkg::CHAR_W'(0)};
                end
            end else begin
                r_tvalid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/publish_topic_scanner_unit.sv
// Publish topic scanner: finds a publish header in a payload byte stream,
// streams the printable topic characters and closes each payload with a summary.
// Input beats carry one payload byte, tlast marks the final byte of a payload.
// Output beats: tuser 0 is a topic character, tuser 1 the end-of-payload summary
// with found flag, qos level and printable count; tlast marks the final beat
// caused by one input byte. A consumer drops the characters of a payload whose
// summary has the found flag low.
// Throughput: one input byte per cycle while the work queue has room. A byte that yields
// both a character and a summary gives two output beats from the single output register.
// A result is registered first in the work queue and then in the output register. The
// parser front writes a four-entry work queue; the back end reads it, so the input
// keeps flowing while a result waits downstream.
// When the receiver stalls, the queue fills and s_axis_tready drops once it
// is full; results held in the output register stay stable.
// Reset (synchronous, active low) empties the queue, drops the output beat
// and returns the parser to scanning with an empty byte history.
// depends on pts_pkg, pts_front, pts_queue, pts_back
module publish_topic_scanner_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tlast,   // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [6:0] topic_char,
                                                                // [7] found_valid,
                                                                // [8] qos_level,
                                                                // [16:9] printable_count
    output logic                                m_axis_tuser,   // item_kind
    output logic                                m_axis_tlast    // last_of_run
);

    logic                   w_accept;
    logic                   w_push;
    logic                   w_pop;
    pts_pkg::t_work         w_in_work;
    pts_pkg::t_work         w_head_work;
    pts_pkg::t_queue_status w_status;

    assign s_axis_tready = !w_status.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // byte parser
    pts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .o_push      (w_push),
        .o_work      (w_in_work)
    );

    // work queue
    pts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_work   (w_in_work),
        .i_pop    (w_pop),
        .o_work   (w_head_work),
        .o_status (w_status)
    );

    // result beats
    pts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (w_head_work),
        .i_status (w_status),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
